// ===== sv/barrel_shift_alu_with_flags_macros.svh =====
// assertion macros for the barrel shift alu checker
`ifndef BARREL_SHIFT_ALU_WITH_FLAGS_MACROS_SVH
`define BARREL_SHIFT_ALU_WITH_FLAGS_MACROS_SVH

// implication checked on every clock edge outside reset
`define BSA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// implication whose consequent is checked in the next cycle
`define BSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// ===== sv/bsa_pkg.sv =====
// shared types and constants for the barrel shift alu
`timescale 1ns / 1ps
package bsa_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [3:0] {
    OP_AND = 4'd0, OP_EOR = 4'd1, OP_SUB = 4'd2, OP_RSB = 4'd3,
    OP_ADD = 4'd4, OP_ADC = 4'd5, OP_SBC = 4'd6, OP_RSC = 4'd7,
    OP_TST = 4'd8, OP_TEQ = 4'd9, OP_CMP = 4'd10, OP_CMN = 4'd11,
    OP_ORR = 4'd12, OP_MOV = 4'd13, OP_BIC = 4'd14, OP_MVN = 4'd15
  } opcode_t;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0, SH_LSR = 2'd1, SH_ASR = 2'd2, SH_ROR = 2'd3
  } shift_t;

  // decoded item handed from front to back
  typedef struct packed {
    logic [31:0] insn;
    logic [31:0] rn;
    logic [31:0] rm;
    logic [7:0]  rs8;
    logic        undef;
  } dec_item_t;

endpackage

// ===== sv/bsa_front.sv =====
// front part: accepts and classifies instructions
`timescale 1ns / 1ps
module bsa_front
  import bsa_pkg::*;
(
  input  logic [31:0] in_instruction_word,
  input  logic [31:0] in_first_operand,
  input  logic [31:0] in_shifted_operand,
  input  logic [31:0] in_shift_amount_reg,
  output dec_item_t   item
);

  always_comb begin
    item.insn  = in_instruction_word;
    item.rn    = in_first_operand;
    item.rm    = in_shifted_operand;
    item.rs8   = in_shift_amount_reg[7:0];
    item.undef = !in_instruction_word[25] && in_instruction_word[7] && in_instruction_word[4];
  end

endmodule

// ===== sv/bsa_queue.sv =====
// small queue between front and back
`timescale 1ns / 1ps
module bsa_queue
  import bsa_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
)(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  dec_item_t wr_data,
  output logic      full,
  input  logic      rd_en,
  output dec_item_t rd_data,
  output logic      empty
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  dec_item_t mem [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full    = (cnt_r == (AW+1)'(Depth));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= (wp_r == AW'(Depth - 1)) ? '0 : wp_r + 1'b1;
      end
      if (rd_en) begin
        rp_r <= (rp_r == AW'(Depth - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

endmodule

// ===== sv/bsa_back.sv =====
// back part: condition check, shifter, alu, flags and output register
`timescale 1ns / 1ps
module bsa_back
  import bsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dec_item_t   item,
  input  logic        item_valid,
  output logic        item_take,
  output logic [31:0] out_result_value,
  output logic [3:0]  out_dest_index,
  output logic        out_write_dest,
  output logic        out_executed,
  output logic        out_undefined_insn,
  output logic [3:0]  out_flags_out,
  output logic        empty,
  input  logic        pop
);

  logic [3:0] flags_r, flags_nxt;
  logic       ovalid_r;
  logic       n, z, c, v, pass, exec, sc, co, ov, arith;
  logic [31:0] so, res, a, b, rm;
  logic [32:0] sum;
  logic [3:0] rot;
  logic [4:0] sh;
  logic [7:0] rs8;
  logic       cin_add;
  shift_t     st;
  opcode_t    op;

  assign empty     = !ovalid_r;
  assign item_take = item_valid && (!ovalid_r || pop);

  always_comb begin
    {n, z, c, v} = flags_r;
    case (item.insn[31:28])
      4'd0:    pass = z;
      4'd1:    pass = !z;
      4'd2:    pass = c;
      4'd3:    pass = !c;
      4'd4:    pass = n;
      4'd5:    pass = !n;
      4'd6:    pass = v;
      4'd7:    pass = !v;
      4'd8:    pass = c && !z;
      4'd9:    pass = !c || z;
      4'd10:   pass = (n == v);
      4'd11:   pass = (n != v);
      4'd12:   pass = !z && (n == v);
      4'd13:   pass = z || (n != v);
      4'd14:   pass = 1'b1;
      default: pass = 1'b0;
    endcase
    exec = pass && !item.undef;

    rm  = item.rm;
    rs8 = item.rs8;
    st  = shift_t'(item.insn[6:5]);
    rot = item.insn[11:8];
    sh  = item.insn[11:7];
    so  = rm;
    sc  = c;
    if (item.insn[25]) begin
      so = {24'd0, item.insn[7:0]} >> {rot, 1'b0} | {24'd0, item.insn[7:0]} << (6'd32 - {1'b0, rot, 1'b0});
      if (rot != 4'd0) begin
        sc = so[31];
      end else begin
        so = {24'd0, item.insn[7:0]};
      end
    end else if (!item.insn[4]) begin
      case (st)
        SH_LSL: if (sh != 5'd0) begin
          so = rm << sh;
          sc = rm[5'd0 - sh];
        end
        SH_LSR: if (sh == 5'd0) begin
          so = '0;
          sc = rm[31];
        end else begin
          so = rm >> sh;
          sc = rm[sh - 5'd1];
        end
        SH_ASR: if (sh == 5'd0) begin
          so = {32{rm[31]}};
          sc = rm[31];
        end else begin
          so = 32'($signed(rm) >>> sh);
          sc = rm[sh - 5'd1];
        end
        default: if (sh == 5'd0) begin
          so = {c, rm[31:1]};
          sc = rm[0];
        end else begin
          so = (rm >> sh) | (rm << (6'd32 - {1'b0, sh}));
          sc = rm[sh - 5'd1];
        end
      endcase
    end else if (rs8 != 8'd0) begin
      case (st)
        SH_LSL: if (rs8 < 8'd32) begin
          so = rm << rs8[4:0];
          sc = rm[5'd0 - rs8[4:0]];
        end else begin
          so = '0;
          sc = (rs8 == 8'd32) ? rm[0] : 1'b0;
        end
        SH_LSR: if (rs8 < 8'd32) begin
          so = rm >> rs8[4:0];
          sc = rm[rs8[4:0] - 5'd1];
        end else begin
          so = '0;
          sc = (rs8 == 8'd32) ? rm[31] : 1'b0;
        end
        SH_ASR: if (rs8 < 8'd32) begin
          so = 32'($signed(rm) >>> rs8[4:0]);
          sc = rm[rs8[4:0] - 5'd1];
        end else begin
          so = {32{rm[31]}};
          sc = rm[31];
        end
        default: if (rs8[4:0] == 5'd0) begin
          so = rm;
          sc = rm[31];
        end else begin
          so = (rm >> rs8[4:0]) | (rm << (6'd32 - {1'b0, rs8[4:0]}));
          sc = rm[rs8[4:0] - 5'd1];
        end
      endcase
    end

    op = opcode_t'(item.insn[24:21]);
    a = item.rn;
    b = so;
    cin_add = 1'b0;
    arith = 1'b1;
    case (op)
      OP_SUB, OP_CMP: begin b = ~so; cin_add = 1'b1; end
      OP_RSB: begin a = so; b = ~item.rn; cin_add = 1'b1; end
      OP_ADD, OP_CMN: cin_add = 1'b0;
      OP_ADC: cin_add = c;
      OP_SBC: begin b = ~so; cin_add = c; end
      OP_RSC: begin a = so; b = ~item.rn; cin_add = c; end
      default: arith = 1'b0;
    endcase
    sum = {1'b0, a} + {1'b0, b} + {32'd0, cin_add};
    co  = sum[32];
    ov  = (a[31] ^ sum[31]) & (b[31] ^ sum[31]);
    case (op)
      OP_AND, OP_TST: res = item.rn & so;
      OP_EOR, OP_TEQ: res = item.rn ^ so;
      OP_ORR:         res = item.rn | so;
      OP_MOV:         res = so;
      OP_BIC:         res = item.rn & ~so;
      OP_MVN:         res = ~so;
      default:        res = sum[31:0];
    endcase

    flags_nxt = flags_r;
    if (exec && item.insn[20]) begin
      flags_nxt = {res[31], res == '0, arith ? co : sc, arith ? ov : v};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (item_take) begin
        flags_r  <= flags_nxt;
        ovalid_r <= 1'b1;
      end else if (pop) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      out_result_value   <= exec ? res : '0;
      out_dest_index     <= item.insn[15:12];
      out_write_dest     <= exec && !(op == OP_TST || op == OP_TEQ || op == OP_CMP
                                      || op == OP_CMN);
      out_executed       <= exec;
      out_undefined_insn <= item.undef;
      out_flags_out      <= flags_nxt;
    end
  end

endmodule

// ===== sv/barrel_shift_alu_with_flags.sv =====
// top level of the barrel shift alu with flags
`timescale 1ns / 1ps
// Executes one 32-bit data-processing instruction per transaction. The front part
// classifies the word and places it in a two-entry queue; the back part checks the
// condition against the stored NZCV flags, shifts, runs the alu and registers the
// result. Throughput is one instruction per cycle while the receiver pops, set by
// the flag update loop in the back part; a result is registered in the output
// register once the back part takes its item from the queue. Flags reset to zero.
module barrel_shift_alu_with_flags
  import bsa_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [31:0] in_instruction_word,
  input  logic [31:0] in_first_operand,
  input  logic [31:0] in_shifted_operand,
  input  logic [31:0] in_shift_amount_reg,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_result_value,
  output logic [3:0]  out_dest_index,
  output logic        out_write_dest,
  output logic        out_executed,
  output logic        out_undefined_insn,
  output logic [3:0]  out_flags_out
);

  dec_item_t fr_item, q_item;
  logic      q_empty, q_take;

  bsa_front u_front (
    .in_instruction_word, .in_first_operand, .in_shifted_operand,
    .in_shift_amount_reg, .item(fr_item)
  );

  bsa_queue #(.Depth(Depth)) u_queue (
    .clk, .rst_n, .wr_en(push && !full), .wr_data(fr_item), .full,
    .rd_en(q_take), .rd_data(q_item), .empty(q_empty)
  );

  bsa_back u_back (
    .clk, .rst_n, .item(q_item), .item_valid(!q_empty), .item_take(q_take),
    .out_result_value, .out_dest_index, .out_write_dest, .out_executed,
    .out_undefined_insn, .out_flags_out, .empty, .pop
  );

endmodule

// ===== sv/bsa_checker.sv =====
// port-level assertion checker for the barrel shift alu
`timescale 1ns / 1ps
`include "barrel_shift_alu_with_flags_macros.svh"
module bsa_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       empty,
  input logic       pop,
  input logic       out_write_dest,
  input logic       out_executed,
  input logic       out_undefined_insn,
  input logic [3:0] out_flags_out
);

  `BSA_ASSERT_IMPL(a_wr_exec, !empty && out_write_dest, out_executed)
  `BSA_ASSERT_IMPL(a_undef_noexec, !empty && out_undefined_insn, !out_executed)
  `BSA_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_flags_out))

endmodule

bind barrel_shift_alu_with_flags bsa_checker u_bsa_checker (
  .clk, .rst_n, .empty, .pop, .out_write_dest, .out_executed,
  .out_undefined_insn, .out_flags_out
);

// ===== verif/tb_top.sv =====
// self-checking testbench for the barrel shift alu with flags
`timescale 1ns / 1ps
class alu_scoreboard;
  logic [3:0] nzcv;
  logic [42:0] pending[$];
  int errors;
  int shown;

  function void clear();
    nzcv = 4'd0;
    pending.delete();
    errors = 0;
    shown = 0;
  endfunction

  function bit cond_ok(logic [3:0] c);
    logic n, z, cf, v;
    n = nzcv[3];
    z = nzcv[2];
    cf = nzcv[1];
    v = nzcv[0];
    case (c)
      4'd0: return z;
      4'd1: return !z;
      4'd2: return cf;
      4'd3: return !cf;
      4'd4: return n;
      4'd5: return !n;
      4'd6: return v;
      4'd7: return !v;
      4'd8: return cf && !z;
      4'd9: return !cf || z;
      4'd10: return n == v;
      4'd11: return n != v;
      4'd12: return !z && (n == v);
      4'd13: return z || (n != v);
      4'd14: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function void note_insn(logic [31:0] ins, logic [31:0] rn, logic [31:0] rm,
                          logic [31:0] rs);
    logic [7:0] rs8;
    logic [4:0] sh;
    logic [4:0] rot;
    logic [31:0] so, res, b;
    logic [32:0] sum;
    logic sc, cin, undef, exec, wr, arith, co, ov, ci;
    bsa_pkg::opcode_t op;
    bsa_pkg::shift_t st;
    rs8 = rs[7:0];
    cin = nzcv[1];
    op = bsa_pkg::opcode_t'(ins[24:21]);
    st = bsa_pkg::shift_t'(ins[6:5]);
    undef = !ins[25] && ins[7] && ins[4];
    exec = !undef && cond_ok(ins[31:28]);
    so = 32'd0;
    sc = cin;
    res = 32'd0;
    wr = 1'b0;
    arith = 1'b0;
    co = 1'b0;
    ov = 1'b0;
    if (exec) begin
      if (ins[25]) begin
        rot = {ins[11:8], 1'b0};
        so = ({24'd0, ins[7:0]} >> rot) | ({24'd0, ins[7:0]} << (6'd32 - rot));
        sc = (rot == 0) ? cin : so[31];
      end else if (!ins[4]) begin
        sh = ins[11:7];
        case (st)
          bsa_pkg::SH_LSL: if (sh == 0) begin so = rm; sc = cin; end
                           else begin so = rm << sh; sc = rm[5'd0 - sh]; end
          bsa_pkg::SH_LSR: if (sh == 0) begin so = 32'd0; sc = rm[31]; end
                           else begin so = rm >> sh; sc = rm[sh - 5'd1]; end
          bsa_pkg::SH_ASR: if (sh == 0) begin so = {32{rm[31]}}; sc = rm[31]; end
                           else begin so = $signed(rm) >>> sh; sc = rm[sh - 5'd1]; end
          default: if (sh == 0) begin so = {cin, rm[31:1]}; sc = rm[0]; end
                   else begin so = (rm >> sh) | (rm << (6'd32 - sh)); sc = rm[sh - 5'd1]; end
        endcase
      end else if (rs8 == 0) begin
        so = rm;
        sc = cin;
      end else begin
        case (st)
          bsa_pkg::SH_LSL:
            if (rs8 < 32) begin so = rm << rs8; sc = rm[5'd0 - rs8[4:0]]; end
            else if (rs8 == 32) begin so = 32'd0; sc = rm[0]; end
            else begin so = 32'd0; sc = 1'b0; end
          bsa_pkg::SH_LSR:
            if (rs8 < 32) begin so = rm >> rs8; sc = rm[rs8[4:0] - 5'd1]; end
            else if (rs8 == 32) begin so = 32'd0; sc = rm[31]; end
            else begin so = 32'd0; sc = 1'b0; end
          bsa_pkg::SH_ASR:
            if (rs8 < 32) begin so = $signed(rm) >>> rs8; sc = rm[rs8[4:0] - 5'd1]; end
            else begin so = {32{rm[31]}}; sc = rm[31]; end
          default: begin
            sh = rs8[4:0];
            if (sh == 0) begin so = rm; sc = rm[31]; end
            else begin so = (rm >> sh) | (rm << (6'd32 - sh)); sc = rm[sh - 5'd1]; end
          end
        endcase
      end
      // operand pair and carry in for the adder
      arith = 1'b1;
      case (op)
        bsa_pkg::OP_SUB, bsa_pkg::OP_CMP: begin b = ~so; ci = 1'b1; res = rn; end
        bsa_pkg::OP_RSB: begin b = ~rn; ci = 1'b1; res = so; end
        bsa_pkg::OP_ADD, bsa_pkg::OP_CMN: begin b = so; ci = 1'b0; res = rn; end
        bsa_pkg::OP_ADC: begin b = so; ci = cin; res = rn; end
        bsa_pkg::OP_SBC: begin b = ~so; ci = cin; res = rn; end
        bsa_pkg::OP_RSC: begin b = ~rn; ci = cin; res = so; end
        default: begin arith = 1'b0; b = 32'd0; ci = 1'b0; end
      endcase
      if (arith) begin
        sum = {1'b0, res} + {1'b0, b} + {32'd0, ci};
        co = sum[32];
        ov = (res[31] ^ sum[31]) & (b[31] ^ sum[31]);
        res = sum[31:0];
      end else begin
        case (op)
          bsa_pkg::OP_AND, bsa_pkg::OP_TST: res = rn & so;
          bsa_pkg::OP_EOR, bsa_pkg::OP_TEQ: res = rn ^ so;
          bsa_pkg::OP_ORR: res = rn | so;
          bsa_pkg::OP_MOV: res = so;
          bsa_pkg::OP_BIC: res = rn & ~so;
          default: res = ~so;
        endcase
      end
      wr = !(op inside {bsa_pkg::OP_TST, bsa_pkg::OP_TEQ, bsa_pkg::OP_CMP,
                        bsa_pkg::OP_CMN});
      if (ins[20])
        nzcv = {res[31], res == 0, arith ? co : sc, arith ? ov : nzcv[0]};
    end
    pending.push_back({(exec ? res : 32'd0), ins[15:12], wr, exec, undef, nzcv});
  endfunction

  function void check_result(logic [42:0] got);
    logic [42:0] want;
    if (pending.size() == 0) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("unexpected transaction %h", got);
      end
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("mismatch: res %h/%h rd %0d/%0d wr %b/%b ex %b/%b ud %b/%b nzcv %h/%h",
                 want[42:11], got[42:11], want[10:7], got[10:7], want[6], got[6],
                 want[5], got[5], want[4], got[4], want[3:0], got[3:0]);
      end
    end
  endfunction
endclass

module tb_top;
  import bsa_pkg::*;
  logic clk, rst_n, push, full, empty, pop;
  logic [31:0] ins_d, rn_d, rm_d, rs_d;
  logic [31:0] res_q;
  logic [3:0] rd_q, nzcv_q;
  logic wr_q, ex_q, ud_q;
  alu_scoreboard sb;
  int idle_cycles;
  bit done;

  barrel_shift_alu_with_flags uut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_instruction_word(ins_d), .in_first_operand(rn_d),
    .in_shifted_operand(rm_d), .in_shift_amount_reg(rs_d),
    .empty(empty), .pop(pop), .out_result_value(res_q), .out_dest_index(rd_q),
    .out_write_dest(wr_q), .out_executed(ex_q), .out_undefined_insn(ud_q),
    .out_flags_out(nzcv_q)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFFFFFF;
      2: return 32'h80000000;
      3: return 32'h7FFFFFFF;
      default: return $urandom();
    endcase
  endfunction

  // send one transaction, holding it until accepted
  task automatic send(logic [31:0] ins, logic [31:0] rn, logic [31:0] rm, logic [31:0] rs);
    ins_d <= ins;
    rn_d <= rn;
    rm_d <= rm;
    rs_d <= rs;
    push <= 1'b1;
    do @(posedge clk); while (full);
    sb.note_insn(ins, rn, rm, rs);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic [31:0] ins, rs;
    ins = $urandom();
    // force the always-condition on about one word in three so flags get a chance to move
    if ($urandom_range(0, 2) == 0) ins[31:28] = 4'hE;
    // keep the extension space rare
    if (!ins[25] && ins[7] && ins[4] && $urandom_range(0, 3) != 0) ins[7] = 1'b0;
    case ($urandom_range(0, 3))
      0: rs = $urandom_range(0, 40);
      1: rs = {24'($urandom_range(0, 16777215)), 8'd32};
      default: rs = $urandom();
    endcase
    send(ins, rand_word(), rand_word(), rs);
  endtask

  // receiver with its own stall pattern
  initial begin
    int phase;
    pop = 1'b0;
    phase = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      phase++;
      if (phase % 200 < 60) pop <= 1'b1;
      else pop <= ($urandom_range(0, 3) != 0) && (phase % 7 != 3);
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty)
      sb.check_result({res_q, rd_q, wr_q, ex_q, ud_q, nzcv_q});
  end

  // watchdog on accepted transactions
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000 && !done) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int sent, burst, k;
    logic [3:0] op;
    sb = new();
    sb.clear();
    idle_cycles = 0;
    done = 1'b0;
    push = 1'b0;
    ins_d = 32'd0;
    rn_d = 32'd0;
    rm_d = 32'd0;
    rs_d = 32'd0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // directed: every opcode with s set, shifter special forms, conditions
    for (k = 0; k < 16; k++) begin
      op = 4'(k);
      send({4'hE, 3'b000, op, 1'b1, 4'h1, 4'h2, 12'h000}, 32'hFFFFFFFF, 32'h80000000,
           32'd0);
    end
    send({4'hE, 3'b001, OP_MOV, 1'b1, 4'h0, 4'hF, 12'hF81}, 32'd0, 32'd0, 32'd0);
    send({4'hE, 3'b000, OP_MOV, 1'b1, 4'h0, 4'h3, 12'h020}, 32'd0, 32'h80000001, 32'd0);
    send({4'hE, 3'b000, OP_MOV, 1'b1, 4'h0, 4'h3, 12'h040}, 32'd0, 32'h80000001, 32'd0);
    send({4'hE, 3'b000, OP_MOV, 1'b1, 4'h0, 4'h3, 12'h060}, 32'd0, 32'h80000001, 32'd0);
    send({4'hE, 3'b000, OP_MOV, 1'b1, 4'h0, 4'h3, 12'h210}, 32'd0, 32'h80000001, 32'd32);
    send({4'hE, 3'b000, OP_MOV, 1'b1, 4'h0, 4'h3, 12'h230}, 32'd0, 32'h80000001, 32'd33);
    send({4'hE, 3'b000, OP_MOV, 1'b1, 4'h0, 4'h3, 12'h270}, 32'd0, 32'h80000001, 32'd64);
    send({4'hF, 3'b000, OP_ADD, 1'b1, 4'h0, 4'h4, 12'h000}, 32'd1, 32'd1, 32'd0);
    send({4'h0, 3'b000, OP_ADD, 1'b1, 4'h0, 4'h4, 12'h090}, 32'd1, 32'd1, 32'd0);
    sent = 0;
    while (sent < 1030) begin
      burst = $urandom_range(1, 40);
      for (k = 0; k < burst; k++) begin
        send_random();
        sent++;
      end
      if (sent > 500 && sent < 541) begin
        push <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      if ($urandom_range(0, 3) != 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    done = 1'b1;
    if (sb.errors == 0 && sb.pending.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
